// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants and round functions for the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned ChainWords = 8;
   localparam int unsigned Rounds     = 64;
   localparam logic [7:0]  PadMark    = 8'h80;
   localparam logic [63:0] BlockBits  = 64'd512;

   localparam logic [31:0] ROUND_K [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [ChainWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

// ===== rtl/sha_ram.sv =====
// ----------------------------------------------------------------------------
// sha_ram
// Generic simple dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sha_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// SHA-256 compression of one 16-word block held in a schedule RAM. The
// schedule expands in a sixteen-word shift-register window at one round per cycle.
// ----------------------------------------------------------------------------
module sha_core
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] h_in [ChainWords],
   // Block loading port into the schedule RAM.
   input  logic        load_en,
   input  logic [3:0]  load_addr,
   input  logic [31:0] load_data,
   output logic        done,
   output logic [31:0] h_out [ChainWords]
);

   typedef enum logic [1:0] {IDLE, PREP, RUN, FINISH} state_type;

   state_type   state_ff;
   logic [6:0]  round_ff;
   logic [31:0] v_ff [ChainWords];
   logic [31:0] h_ff [ChainWords];
   // Last sixteen schedule words in registers: w_ff[0] is w[t].
   logic [31:0] w_ff [16];
   logic        done_ff;

   logic        ram_wr;
   logic [3:0]  ram_waddr;
   logic [31:0] ram_wdata;
   logic [3:0]  ram_raddr;
   logic [31:0] ram_rdata;
   logic [31:0] w_new;
   logic [31:0] t1, t2;

   // Block words live in RAM; during PREP they stream into the window.
   assign ram_wr    = load_en;
   assign ram_waddr = load_addr;
   assign ram_wdata = load_data;
   assign ram_raddr = round_ff[3:0];

   sha_ram #(.Width(32), .Depth(16)) u_sched (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Next schedule word from the window.
   assign w_new = w_ff[0] + small_s0(w_ff[1]) + w_ff[9] + small_s1(w_ff[14]);

   // Round datapath.
   always_comb begin
      t1 = v_ff[7] + big_s1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + ROUND_K[round_ff[5:0]] + w_ff[0];
      t2 = big_s0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign done  = done_ff;
   assign h_out = h_ff;

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= IDLE;
         round_ff <= '0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  state_ff <= PREP;
                  round_ff <= 7'd1;
                  v_ff     <= h_in;
                  h_ff     <= h_in;
               end else begin
                  round_ff <= '0;
               end
            end
            // Read all sixteen words through the registered RAM read port into the window.
            PREP: begin
               for (int i = 0; i < 15; i++) begin
                  w_ff[i] <= w_ff[i+1];
               end
               w_ff[15] <= ram_rdata;
               if (round_ff == 7'd16) begin
                  state_ff <= RUN;
                  round_ff <= '0;
               end else begin
                  round_ff <= round_ff + 7'd1;
               end
            end
            RUN: begin
               for (int i = 0; i < 15; i++) begin
                  w_ff[i] <= w_ff[i+1];
               end
               w_ff[15] <= w_new;
               for (int i = 1; i < 8; i++) begin
                  v_ff[i] <= v_ff[i-1];
               end
               v_ff[4] <= v_ff[3] + t1;
               v_ff[0] <= t1 + t2;
               if (round_ff == 7'(Rounds - 1)) begin
                  state_ff <= FINISH;
               end
               round_ff <= round_ff + 7'd1;
            end
            FINISH: begin
               for (int i = 0; i < 8; i++) begin
                  h_ff[i] <= h_ff[i] + v_ff[i];
               end
               done_ff  <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-stream SHA-256: packs bytes into 32-bit words, compresses full blocks,
// pads on the final word and emits the eight-word digest.
// ----------------------------------------------------------------------------
// A byte that does not fill a block is accepted without a stall. A byte that fills
// a block stalls the input while it is compressed: start, 16 schedule loads,
// 64 rounds, the chaining add and the handoff.
// A final word adds the padding words and one compression for each padded block
// (one or two), then eight output words at one per cycle while rsp_ready is high.
// Reset is synchronous: chaining words return to the initial values and the
// byte and bit counters clear; the block contents stay undefined.
module sha256_stream_hasher
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {ACCEPT, COMP, PAD, LEN, OUT} state_type;

   state_type   state_ff;
   logic [31:0] chain_ff [ChainWords];
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [23:0] part_ff;      // bytes of the word now being packed
   logic        finish_ff;    // padding still to do after this compression
   logic        final_ff;     // this compression closes the message
   logic [63:0] total_ff;
   logic [3:0]  pad_ff;       // word address written during padding
   logic [2:0]  out_idx_ff;
   logic        start_ff;

   logic        load_en;
   logic [3:0]  load_addr;
   logic [31:0] load_data;
   logic        core_done;
   logic [31:0] core_h [ChainWords];

   logic        accept;
   logic [5:0]  fill_in;
   logic [31:0] mark_word;

   sha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .h_in      (chain_ff),
      .load_en   (load_en),
      .load_addr (load_addr),
      .load_data (load_data),
      .done      (core_done),
      .h_out     (core_h)
   );

   assign req_ready = (state_ff == ACCEPT);
   assign accept    = req_valid && req_ready;
   assign fill_in   = fill_ff + 6'd1;

   // Word with the pad mark placed after the bytes already packed.
   always_comb begin
      case (fill_ff[1:0])
         2'd0:    mark_word = {PadMark, 24'h0};
         2'd1:    mark_word = {part_ff[7:0], PadMark, 16'h0};
         2'd2:    mark_word = {part_ff[15:0], PadMark, 8'h0};
         default: mark_word = {part_ff[23:0], PadMark};
      endcase
   end

   // Schedule RAM writes: packed bytes in ACCEPT, pad and length words later.
   always_comb begin
      load_en   = 1'b0;
      load_addr = fill_ff[5:2];
      load_data = {part_ff, req_msg_byte};
      if (state_ff == ACCEPT) begin
         load_en = accept && req_byte_present && (fill_ff[1:0] == 2'd3);
      end else if (state_ff == PAD) begin
         load_en   = 1'b1;
         load_addr = pad_ff;
         load_data = (pad_ff == fill_ff[5:2]) ? mark_word : 32'h0;
         if (pad_ff < fill_ff[5:2]) begin
            load_en = 1'b0;
         end
      end else if (state_ff == LEN) begin
         // Zeros up to word 13, then the two length words.
         load_en   = 1'b1;
         load_addr = pad_ff;
         if (pad_ff == 4'd14) begin
            load_data = total_ff[63:32];
         end else if (pad_ff == 4'd15) begin
            load_data = total_ff[31:0];
         end else begin
            load_data = 32'h0;
         end
      end
   end

   assign rsp_valid       = (state_ff == OUT);
   assign rsp_digest_word = chain_ff[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      start_ff <= 1'b0;
      if (reset) begin
         state_ff   <= ACCEPT;
         chain_ff   <= INIT_H;
         fill_ff    <= '0;
         bits_ff    <= '0;
         finish_ff  <= 1'b0;
         final_ff   <= 1'b0;
         out_idx_ff <= '0;
         pad_ff     <= '0;
      end else begin
         unique case (state_ff)
            ACCEPT: begin
               if (accept) begin
                  if (req_byte_present) begin
                     part_ff <= {part_ff[15:0], req_msg_byte};
                     fill_ff <= fill_in;
                  end
                  if (req_byte_present && (fill_ff == 6'd63)) begin
                     // Full block: compress, then pad if the word was final.
                     start_ff  <= 1'b1;
                     finish_ff <= req_end_of_message;
                     final_ff  <= 1'b0;
                     state_ff  <= COMP;
                  end else if (req_end_of_message) begin
                     total_ff <= bits_ff + {55'd0, (req_byte_present ? fill_in : fill_ff), 3'd0};
                     pad_ff   <= req_byte_present ? fill_in[5:2] : fill_ff[5:2];
                     state_ff <= PAD;
                  end
               end
            end
            COMP: begin
               if (core_done) begin
                  chain_ff <= core_h;
                  if (final_ff) begin
                     out_idx_ff <= '0;
                     state_ff   <= OUT;
                  end else if (finish_ff) begin
                     finish_ff <= 1'b0;
                     if (fill_ff != 6'd0) begin
                        // Mark already written; remaining block is zeros plus length.
                        pad_ff <= '0;
                        fill_ff <= 6'd0;
                        part_ff <= '0;
                        state_ff <= LEN;
                     end else begin
                        total_ff <= bits_ff + BlockBits;
                        bits_ff  <= bits_ff + BlockBits;
                        pad_ff   <= '0;
                        state_ff <= PAD;
                     end
                  end else begin
                     bits_ff  <= bits_ff + BlockBits;
                     state_ff <= ACCEPT;
                  end
               end
            end
            // Mark word then zeros up to word 13, or word 15 if no room for length.
            PAD: begin
               if (fill_ff >= 6'd56) begin
                  if (pad_ff == 4'd15) begin
                     start_ff  <= 1'b1;
                     finish_ff <= 1'b1;
                     final_ff  <= 1'b0;
                     total_ff  <= total_ff;
                     fill_ff   <= 6'd1;
                     state_ff  <= COMP;
                  end
                  pad_ff <= pad_ff + 4'd1;
               end else begin
                  if (pad_ff == 4'd13) begin
                     state_ff <= LEN;
                  end
                  pad_ff <= pad_ff + 4'd1;
               end
            end
            // Zero words before the length, then the two length words.
            LEN: begin
               if (pad_ff == 4'd15) begin
                  start_ff <= 1'b1;
                  final_ff <= 1'b1;
                  state_ff <= COMP;
               end
               pad_ff <= pad_ff + 4'd1;
            end
            OUT: begin
               if (rsp_ready) begin
                  out_idx_ff <= out_idx_ff + 3'd1;
                  if (out_idx_ff == 3'd7) begin
                     chain_ff  <= INIT_H;
                     fill_ff   <= '0;
                     bits_ff   <= '0;
                     final_ff  <= 1'b0;
                     finish_ff <= 1'b0;
                     state_ff  <= ACCEPT;
                  end
               end
            end
            default: state_ff <= ACCEPT;
         endcase
      end
   end

endmodule
